// File: rtl/vrp_pkg.sv
package vrp_pkg;

   localparam int COORD_BITS_DEF    = 16;
   localparam int FRACTION_BITS_DEF = 12;
   localparam int TRIG_FRAC         = 14;
   localparam int PIXEL_FRAC        = 4;
   localparam int DEPTH_FRAC        = 12;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [2:0] REG_PLANE  = 3'd0;
   localparam logic [2:0] REG_COSINE = 3'd1;
   localparam logic [2:0] REG_SINE   = 3'd2;
   localparam logic [2:0] REG_DEPTH  = 3'd3;
   localparam logic [2:0] REG_WIDTH  = 3'd4;
   localparam logic [2:0] REG_HEIGHT = 3'd5;

   localparam logic [1:0] PLANE_XZ = 2'd0;
   localparam logic [1:0] PLANE_XY = 2'd1;
   localparam logic [1:0] PLANE_YZ = 2'd2;

   localparam logic [1:0]         RESET_PLANE  = PLANE_XZ;
   localparam logic signed [15:0] RESET_COSINE = 16'sd16384;
   localparam logic signed [15:0] RESET_SINE   = 16'sd0;
   localparam logic signed [15:0] RESET_DEPTH  = 16'sd4096;
   localparam logic [10:0]        RESET_SCREEN = 11'd700;

   // sideband that travels with an item through the divider cells
   typedef struct packed {
      logic sign_x;
      logic sign_y;
      logic zero;
      logic ovf_x;
      logic ovf_y;
   } flag_type;

endpackage

// File: rtl/vrp_front.sv
module vrp_front #(
   parameter int CB = vrp_pkg::COORD_BITS_DEF,
   parameter int FB = vrp_pkg::FRACTION_BITS_DEF,
   parameter int RW = CB + 3,
   parameter int ZW = 20,
   parameter int CW = 36
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [CB-1:0] in_x,
   input  logic signed [CB-1:0] in_y,
   input  logic signed [CB-1:0] in_z,
   input  logic [1:0]           plane,
   input  logic signed [15:0]   cosine,
   input  logic signed [15:0]   sine,
   input  logic signed [15:0]   depth,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [CW-1:0]        out_rem_x,
   output logic [CW-1:0]        out_rem_y,
   output logic [ZW-1:0]        out_den,
   output vrp_pkg::flag_type    out_flags
);
   import vrp_pkg::*;

   localparam int PW = CB + 16;
   localparam int SW = CB + 17;
   localparam int UP = (FB >= DEPTH_FRAC) ? FB - DEPTH_FRAC : 0;
   localparam int DN = (FB < DEPTH_FRAC) ? DEPTH_FRAC - FB : 0;
   localparam int OW = (RW > ZW + 4) ? RW : ZW + 4;

   logic va_ff, vb_ff, vc_ff;
   logic rdy_a, rdy_b, rdy_c;

   logic signed [CB-1:0] op_a, op_b;
   logic signed [PW-1:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [CB-1:0] xa_ff, ya_ff, za_ff;
   logic [1:0]           pa_ff;

   logic signed [SW-1:0] s1, s2;
   logic signed [RW-1:0] r1, r2, rx_in, ry_in, rz_in;
   logic signed [ZW-1:0] d_ext, zd_in;
   logic signed [RW-1:0] rx_ff, ry_ff;
   logic signed [ZW-1:0] zd_ff;

   logic [RW-1:0] ax, ay;
   logic [ZW-1:0] den;
   logic [OW-1:0] den_sh;
   logic [CW-1:0] rem_x_ff, rem_y_ff;
   logic [ZW-1:0] den_ff;
   flag_type      flags_ff, flags_in;

   assign rdy_c    = !vc_ff || out_ready;
   assign rdy_b    = !vb_ff || rdy_c;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= in_valid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
      end
   end

   // pick the coordinate pair of the rotation plane
   always_comb begin
      case (plane)
         PLANE_XY: begin
            op_a = in_x;
            op_b = in_y;
         end
         PLANE_YZ: begin
            op_a = in_y;
            op_b = in_z;
         end
         default: begin
            op_a = in_x;
            op_b = in_z;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         ac_ff <= PW'(op_a * cosine);
         bs_ff <= PW'(op_b * sine);
         as_ff <= PW'(op_a * sine);
         bc_ff <= PW'(op_b * cosine);
         xa_ff <= in_x;
         ya_ff <= in_y;
         za_ff <= in_z;
         pa_ff <= plane;
      end
   end

   always_comb begin
      s1 = SW'(ac_ff) - SW'(bs_ff) + SW'(1 <<< (TRIG_FRAC - 1));
      s2 = SW'(as_ff) + SW'(bc_ff) + SW'(1 <<< (TRIG_FRAC - 1));
      r1 = s1[TRIG_FRAC +: RW];
      r2 = s2[TRIG_FRAC +: RW];
      rx_in = RW'(xa_ff);
      ry_in = RW'(ya_ff);
      rz_in = RW'(za_ff);
      case (pa_ff)
         PLANE_XZ: begin
            rx_in = r1;
            rz_in = r2;
         end
         PLANE_XY: begin
            rx_in = r1;
            ry_in = r2;
         end
         PLANE_YZ: begin
            ry_in = r1;
            rz_in = r2;
         end
         default: ;
      endcase
      d_ext = (ZW'(depth) <<< UP) >>> DN;
      zd_in = ZW'(rz_in) + d_ext;
   end

   always_ff @(posedge clock) begin
      if (rdy_b) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         zd_ff <= zd_in;
      end
   end

   always_comb begin
      ax  = rx_ff[RW-1] ? RW'(-rx_ff) : RW'(rx_ff);
      ay  = ry_ff[RW-1] ? RW'(-ry_ff) : RW'(ry_ff);
      den = zd_ff[ZW-1] ? ZW'(-zd_ff) : ZW'(zd_ff);
      den_sh = OW'(den) << 4;
      flags_in.sign_x = rx_ff[RW-1] ^ zd_ff[ZW-1];
      flags_in.sign_y = ry_ff[RW-1] ^ zd_ff[ZW-1];
      flags_in.zero   = (zd_ff == '0);
      // quotient would need more than FB+4 bits
      flags_in.ovf_x  = (OW'(ax) >= den_sh);
      flags_in.ovf_y  = (OW'(ay) >= den_sh);
   end

   always_ff @(posedge clock) begin
      if (rdy_c) begin
         rem_x_ff <= CW'(ax) << FB;
         rem_y_ff <= CW'(ay) << FB;
         den_ff   <= den;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_den   = den_ff;
   assign out_flags = flags_ff;

endmodule

// File: rtl/vrp_div_cell.sv
module vrp_div_cell #(
   parameter int CW = 36,
   parameter int ZW = 20,
   parameter int QB = 16,
   parameter int K  = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CW-1:0]     in_rem_x,
   input  logic [CW-1:0]     in_rem_y,
   input  logic [ZW-1:0]     in_den,
   input  logic [QB-1:0]     in_q_x,
   input  logic [QB-1:0]     in_q_y,
   input  vrp_pkg::flag_type in_flags,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CW-1:0]     out_rem_x,
   output logic [CW-1:0]     out_rem_y,
   output logic [ZW-1:0]     out_den,
   output logic [QB-1:0]     out_q_x,
   output logic [QB-1:0]     out_q_y,
   output vrp_pkg::flag_type out_flags
);
   import vrp_pkg::*;

   logic          v_ff;
   logic [CW-1:0] dsh;
   logic          ge_x, ge_y;
   logic [CW-1:0] rem_x_ff, rem_y_ff;
   logic [ZW-1:0] den_ff;
   logic [QB-1:0] q_x_ff, q_y_ff;
   flag_type      flags_ff;

   assign in_ready = !v_ff || out_ready;
   assign dsh  = CW'(in_den) << K;
   assign ge_x = (in_rem_x >= dsh);
   assign ge_y = (in_rem_y >= dsh);

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (in_ready) v_ff <= in_valid;
   end

   // one restoring step per lane: settle quotient bit K
   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_x_ff <= ge_x ? in_rem_x - dsh : in_rem_x;
         rem_y_ff <= ge_y ? in_rem_y - dsh : in_rem_y;
         q_x_ff   <= in_q_x | (QB'(ge_x) << K);
         q_y_ff   <= in_q_y | (QB'(ge_y) << K);
         den_ff   <= in_den;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = v_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_den   = den_ff;
   assign out_q_x   = q_x_ff;
   assign out_q_y   = q_y_ff;
   assign out_flags = flags_ff;

endmodule

// File: rtl/vrp_back.sv
module vrp_back #(
   parameter int FB = vrp_pkg::FRACTION_BITS_DEF,
   parameter int QB = FB + 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [QB-1:0]      in_q_x,
   input  logic [QB-1:0]      in_q_y,
   input  vrp_pkg::flag_type  in_flags,
   input  logic [10:0]        screen_w,
   input  logic [10:0]        screen_h,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [15:0] pixel_x,
   output logic signed [15:0] pixel_y,
   output logic               depth_zero,
   output logic               clipped
);
   import vrp_pkg::*;

   localparam int UW = FB + 5;
   localparam int MW = UW + 12;
   localparam int SH = FB + 1 - PIXEL_FRAC;
   localparam logic [QB-1:0]      LIM = QB'(8) << FB;
   localparam logic signed [UW-1:0] ONE = UW'(1) <<< FB;

   logic vd_ff, ve_ff, rdy_d, rdy_e;
   logic clx, cly;
   logic [QB-1:0] mx, my;
   logic signed [UW-1:0] qxs, qys, upx, upy;
   logic signed [MW-1:0] prod_x_ff, prod_y_ff, rx, ry;
   logic qclip_ff, zero_ff;
   logic px_hi, px_lo, py_hi, py_lo;
   logic signed [15:0] px_ff, py_ff, px_in, py_in;
   logic zero_out_ff, clip_ff, clip_in;

   assign rdy_e    = !ve_ff || out_ready;
   assign rdy_d    = !vd_ff || rdy_e;
   assign in_ready = rdy_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         if (rdy_d) vd_ff <= in_valid;
         if (rdy_e) ve_ff <= vd_ff;
      end
   end

   // clamp the quotients to +-8, apply sign, offset by one
   always_comb begin
      clx = in_flags.ovf_x || (in_q_x > LIM);
      cly = in_flags.ovf_y || (in_q_y > LIM);
      mx  = clx ? LIM : in_q_x;
      my  = cly ? LIM : in_q_y;
      qxs = in_flags.sign_x ? -UW'(mx) : UW'(mx);
      qys = in_flags.sign_y ? -UW'(my) : UW'(my);
      upx = ONE + qxs;
      upy = ONE - qys;
   end

   always_ff @(posedge clock) begin
      if (rdy_d) begin
         prod_x_ff <= MW'(upx * $signed({1'b0, screen_w}));
         prod_y_ff <= MW'(upy * $signed({1'b0, screen_h}));
         qclip_ff  <= clx || cly;
         zero_ff   <= in_flags.zero;
      end
   end

   always_comb begin
      rx = (prod_x_ff + MW'(1 <<< (SH - 1))) >>> SH;
      ry = (prod_y_ff + MW'(1 <<< (SH - 1))) >>> SH;
      px_hi = rx > MW'(32767);
      px_lo = rx < -MW'(32768);
      py_hi = ry > MW'(32767);
      py_lo = ry < -MW'(32768);
      px_in = px_hi ? 16'sh7FFF : (px_lo ? 16'sh8000 : rx[15:0]);
      py_in = py_hi ? 16'sh7FFF : (py_lo ? 16'sh8000 : ry[15:0]);
      clip_in = qclip_ff || px_hi || px_lo || py_hi || py_lo;
      if (zero_ff) begin
         px_in   = 16'({screen_w, 3'b000});
         py_in   = 16'({screen_h, 3'b000});
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_e) begin
         px_ff       <= px_in;
         py_ff       <= py_in;
         zero_out_ff <= zero_ff;
         clip_ff     <= clip_in;
      end
   end

   assign out_valid  = ve_ff;
   assign pixel_x    = px_ff;
   assign pixel_y    = py_ff;
   assign depth_zero = zero_out_ff;
   assign clipped    = clip_ff;

endmodule

// File: rtl/vertex_rotate_project_screen_top.sv
// Path from req to rsp: front-end stages, divider cells, then back-end stages.
// Throughput: one item per cycle unless stalled; each stage and divider cell is
//   a register slice whose ready sees only its own occupancy and the next stage.
// The divider is a chain of FRACTION_BITS + 4 cells, one quotient bit per cell.
// Reset: synchronous, active high; clears all valid bits and loads the registers
//   with plane xz, cosine 1.0, sine 0, depth offset 1.0 and a 700 x 700 screen.
module vertex_rotate_project_screen_top #(
   parameter int COORD_BITS    = vrp_pkg::COORD_BITS_DEF,
   parameter int FRACTION_BITS = vrp_pkg::FRACTION_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // coord_x, coord_y, coord_z from bit 0 up, zero padded to bytes
   input  logic [((3*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // pixel_x [15:0], pixel_y [31:16]
   output logic [31:0]                           rsp_tdata,
   // depth_was_zero [0], clipped [1]
   output logic [1:0]                            rsp_tuser,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [vrp_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [vrp_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [vrp_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);
   import vrp_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int FB = FRACTION_BITS;
   localparam int RW = CB + 3;                     // rotated coordinate
   localparam int UP = (FB >= DEPTH_FRAC) ? FB - DEPTH_FRAC : 0;
   localparam int ZW = ((RW > 16 + UP) ? RW : 16 + UP) + 1;   // offset depth
   localparam int QB = FB + 4;                     // quotient magnitude bits
   localparam int NW = RW + FB;                    // dividend magnitude
   localparam int CW = ((NW > ZW + QB) ? NW : ZW + QB) + 1;

   // configuration registers
   logic [1:0]         plane_ff;
   logic signed [15:0] cos_ff, sin_ff, depth_ff;
   logic [10:0]        width_ff, height_ff;
   logic               wr_en;
   logic [2:0]         reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff  <= RESET_PLANE;
         cos_ff    <= RESET_COSINE;
         sin_ff    <= RESET_SINE;
         depth_ff  <= RESET_DEPTH;
         width_ff  <= RESET_SCREEN;
         height_ff <= RESET_SCREEN;
      end else if (wr_en) begin
         case (reg_idx)
            REG_PLANE:  plane_ff  <= csr_pwdata[1:0];
            REG_COSINE: cos_ff    <= csr_pwdata[15:0];
            REG_SINE:   sin_ff    <= csr_pwdata[15:0];
            REG_DEPTH:  depth_ff  <= csr_pwdata[15:0];
            REG_WIDTH:  width_ff  <= csr_pwdata[10:0];
            REG_HEIGHT: height_ff <= csr_pwdata[10:0];
            default: ;  // drop writes to unmapped addresses
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PLANE:  csr_prdata = CSR_DATA_BITS'(plane_ff);
         REG_COSINE: csr_prdata = CSR_DATA_BITS'(cos_ff);
         REG_SINE:   csr_prdata = CSR_DATA_BITS'(sin_ff);
         REG_DEPTH:  csr_prdata = CSR_DATA_BITS'(depth_ff);
         REG_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // front end: rotate, add depth offset, take magnitudes
   logic          f_valid;
   logic [CW-1:0] f_rem_x, f_rem_y;
   logic [ZW-1:0] f_den;
   flag_type      f_flags;

   // divider chain; index 0 is the front end output, QB the last cell
   logic          c_valid [QB+1];
   logic          c_ready [QB+1];
   logic [CW-1:0] c_rem_x [QB+1];
   logic [CW-1:0] c_rem_y [QB+1];
   logic [ZW-1:0] c_den   [QB+1];
   logic [QB-1:0] c_q_x   [QB+1];
   logic [QB-1:0] c_q_y   [QB+1];
   flag_type      c_flags [QB+1];

   vrp_front #(
      .CB (CB),
      .FB (FB),
      .RW (RW),
      .ZW (ZW),
      .CW (CW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_x      (req_tdata[CB-1:0]),
      .in_y      (req_tdata[2*CB-1:CB]),
      .in_z      (req_tdata[3*CB-1:2*CB]),
      .plane     (plane_ff),
      .cosine    (cos_ff),
      .sine      (sin_ff),
      .depth     (depth_ff),
      .out_valid (f_valid),
      .out_ready (c_ready[0]),
      .out_rem_x (f_rem_x),
      .out_rem_y (f_rem_y),
      .out_den   (f_den),
      .out_flags (f_flags)
   );

   assign c_valid[0] = f_valid;
   assign c_rem_x[0] = f_rem_x;
   assign c_rem_y[0] = f_rem_y;
   assign c_den[0]   = f_den;
   assign c_q_x[0]   = '0;
   assign c_q_y[0]   = '0;
   assign c_flags[0] = f_flags;

   // most significant quotient bit first
   for (genvar i = 0; i < QB; i++) begin : g_cell
      vrp_div_cell #(
         .CW (CW),
         .ZW (ZW),
         .QB (QB),
         .K  (QB - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[i]),
         .in_ready  (c_ready[i]),
         .in_rem_x  (c_rem_x[i]),
         .in_rem_y  (c_rem_y[i]),
         .in_den    (c_den[i]),
         .in_q_x    (c_q_x[i]),
         .in_q_y    (c_q_y[i]),
         .in_flags  (c_flags[i]),
         .out_valid (c_valid[i+1]),
         .out_ready (c_ready[i+1]),
         .out_rem_x (c_rem_x[i+1]),
         .out_rem_y (c_rem_y[i+1]),
         .out_den   (c_den[i+1]),
         .out_q_x   (c_q_x[i+1]),
         .out_q_y   (c_q_y[i+1]),
         .out_flags (c_flags[i+1])
      );
   end

   // back end: clamp, map to pixels, saturate, hold the result
   logic signed [15:0] pix_x, pix_y;
   logic               zero_flag, clip_flag;

   vrp_back #(
      .FB (FB),
      .QB (QB)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (c_valid[QB]),
      .in_ready   (c_ready[QB]),
      .in_q_x     (c_q_x[QB]),
      .in_q_y     (c_q_y[QB]),
      .in_flags   (c_flags[QB]),
      .screen_w   (width_ff),
      .screen_h   (height_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .pixel_x    (pix_x),
      .pixel_y    (pix_y),
      .depth_zero (zero_flag),
      .clipped    (clip_flag)
   );

   assign rsp_tdata = {pix_y, pix_x};
   assign rsp_tuser = {clip_flag, zero_flag};

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import vrp_pkg::*;

   // Register index that the block does not decode; writes to it must be ignored
   localparam logic [2:0] REG_UNUSED = 3'd6;
   localparam int         DRAIN_CYCLES = 40;

   typedef struct {
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
      logic               depth_was_zero;
      logic               clipped;
   } screen_point_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;     // coord_x [15:0], coord_y [31:16], coord_z [47:32]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;     // pixel_x [15:0], pixel_y [31:16]
   logic [1:0]  rsp_tuser;     // depth_was_zero [0], clipped [1]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the block's registers, kept at the block's widths
   logic [1:0]         plane_sel;
   logic signed [15:0] cosine_q14;
   logic signed [15:0] sine_q14;
   logic signed [15:0] depth_q12;
   logic [10:0]        width_px;
   logic [10:0]        height_px;

   screen_point_type expected_points[$];
   int   mismatch_count;
   int   points_checked;
   int   zero_depth_seen;
   int   clipped_seen;
   bit   sender_idles;
   bit   receiver_idles;
   int   receiver_hold;

   vertex_rotate_project_screen_top uut (.*);

   // Clock: 20 ns period
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Rotate a pair of Q4.12 coordinates by a Q2.14 cosine/sine; floor shift, halves round up
   function automatic longint rotate_pair(longint a, longint b, bit second);
      longint acc;
      acc = second ? (a * sine_q14 + b * cosine_q14) : (a * cosine_q14 - b * sine_q14);
      return (acc + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
   endfunction

   // Perspective quotient, truncated toward zero, clamped to +-8.0
   function automatic longint clamp_quotient(longint num, longint den, ref bit clip);
      longint limit;
      longint q;
      limit = 64'sd8 <<< 12;
      q = (num <<< 12) / den;
      if (q > limit) begin
         clip = 1'b1;
         q = limit;
      end else if (q < -limit) begin
         clip = 1'b1;
         q = -limit;
      end
      return q;
   endfunction

   // Scale a Q4.12 unit value by a screen size into saturated Q12.4 pixels
   function automatic logic signed [15:0] to_pixels(longint unit, longint dim, ref bit clip);
      longint p;
      p = (unit * dim + (64'sd1 <<< 8)) >>> 9;
      if (p > 32767) begin
         clip = 1'b1;
         p = 32767;
      end else if (p < -32768) begin
         clip = 1'b1;
         p = -32768;
      end
      return p[15:0];
   endfunction

   function automatic screen_point_type project_vertex(logic signed [15:0] vx,
                                                       logic signed [15:0] vy,
                                                       logic signed [15:0] vz);
      screen_point_type pt;
      longint rx, ry, rz, zd, qx, qy;
      bit clip;
      clip = 1'b0;
      rx = vx;
      ry = vy;
      rz = vz;
      case (plane_sel)
         PLANE_XZ: begin
            rx = rotate_pair(vx, vz, 1'b0);
            rz = rotate_pair(vx, vz, 1'b1);
         end
         PLANE_XY: begin
            rx = rotate_pair(vx, vy, 1'b0);
            ry = rotate_pair(vx, vy, 1'b1);
         end
         PLANE_YZ: begin
            ry = rotate_pair(vy, vz, 1'b0);
            rz = rotate_pair(vy, vz, 1'b1);
         end
         default: ;
      endcase
      zd = rz + depth_q12;
      if (zd == 0) begin
         // Point lands on the screen centre
         pt.pixel_x = {width_px, 3'b000};
         pt.pixel_y = {height_px, 3'b000};
         pt.depth_was_zero = 1'b1;
         pt.clipped = 1'b0;
         return pt;
      end
      qx = clamp_quotient(rx, zd, clip);
      qy = clamp_quotient(ry, zd, clip);
      pt.pixel_x = to_pixels(4096 + qx, width_px, clip);
      pt.pixel_y = to_pixels(4096 - qy, height_px, clip);
      pt.depth_was_zero = 1'b0;
      pt.clipped = clip;
      return pt;
   endfunction

   // Send one vertex; valid stays high afterwards so back-to-back items need no gap
   task automatic send_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                              logic signed [15:0] vz);
      int gap;
      gap = sender_idles ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {vz, vy, vx};
      do @(posedge clock); while (!req_tready);
      expected_points.push_back(project_vertex(vx, vy, vz));
   endtask

   // Drop valid, wait until every item has come back, then wait out DRAIN_CYCLES
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands at the access edge
   task automatic write_register(logic [2:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         REG_PLANE:  plane_sel  = value[1:0];
         REG_COSINE: cosine_q14 = value[15:0];
         REG_SINE:   sine_q14   = value[15:0];
         REG_DEPTH:  depth_q12  = value[15:0];
         REG_WIDTH:  width_px   = value[10:0];
         REG_HEIGHT: height_px  = value[10:0];
         default: ;
      endcase
   endtask

   task automatic set_all(logic [1:0] plane, logic [15:0] c, logic [15:0] s,
                          logic [15:0] d, logic [10:0] w, logic [10:0] h);
      wait_drained();
      write_register(REG_PLANE, plane);
      write_register(REG_COSINE, c);
      write_register(REG_SINE, s);
      write_register(REG_DEPTH, d);
      write_register(REG_WIDTH, w);
      write_register(REG_HEIGHT, h);
   endtask

   // Mostly a sensible 3D scene, some of it anywhere in the field range
   task automatic send_random_vertex();
      logic [15:0] vx, vy, vz;
      vx = 16'($urandom);
      vy = 16'($urandom);
      vz = 16'($urandom);
      if ($urandom_range(0, 3) != 0) begin
         vx = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
         vy = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
         vz = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
      end
      // now and then aim for zero depth in the unrotated case
      if ($urandom_range(0, 15) == 0 && plane_sel == PLANE_XY)
         vz = -depth_q12;
      send_vertex(vx, vy, vz);
   endtask

   function automatic logic [15:0] random_trig();
      if ($urandom_range(0, 7) == 0)
         return 16'($urandom);
      return 16'($urandom_range(0, 32768)) - 16'd16384;
   endfunction

   task automatic randomise_registers();
      logic [10:0] w, h;
      w = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(1, 2047));
      h = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(1, 2047));
      set_all(2'($urandom_range(0, 3)), random_trig(), random_trig(), 16'($urandom), w, h);
   endtask

   // Checker: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      screen_point_type want;
      logic signed [15:0] got_x, got_y;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_x = rsp_tdata[15:0];
         got_y = rsp_tdata[31:16];
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: x=%0d y=%0d flags=%b", got_x, got_y, rsp_tuser);
         end else begin
            want = expected_points.pop_front();
            points_checked++;
            zero_depth_seen += want.depth_was_zero;
            clipped_seen += want.clipped;
            if (got_x !== want.pixel_x || got_y !== want.pixel_y ||
                rsp_tuser[0] !== want.depth_was_zero || rsp_tuser[1] !== want.clipped) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch at %0t: exp x=%0d y=%0d z=%b c=%b, got x=%0d y=%0d z=%b c=%b",
                           $realtime, want.pixel_x, want.pixel_y, want.depth_was_zero,
                           want.clipped, got_x, got_y, rsp_tuser[0], rsp_tuser[1]);
            end
         end
      end
   end

   // Receiver: random stalls per item, or a long hold-off when a test asks for one
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (receiver_hold > 0) begin
            n = receiver_hold;
            receiver_hold = 0;
         end else begin
            n = receiver_idles ? $urandom_range(0, 16) : 0;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Reset values, with a point straight ahead of the camera and one at zero depth
   task automatic test_reset_values();
      send_vertex(16'sd0, 16'sd0, 16'sd0);
      send_vertex(16'sd4096, -16'sd4096, 16'sd4096);
      send_vertex(16'sd1000, 16'sd2000, -16'sd4096);
      send_vertex(16'sd100, 16'sd100, -16'sd4095);
   endtask

   // Field extremes under every plane, including the unused plane code
   task automatic test_field_extremes();
      logic [1:0] plane;
      for (int p = 0; p < 4; p++) begin
         plane = 2'(p);
         set_all(plane, 16'd11585, 16'd11585, 16'd4096, 11'd640, 11'd480);
         send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff);
         send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
         send_vertex(16'sh7fff, 16'sh8000, 16'sd0);
         send_vertex(16'sd1, -16'sd1, 16'sd4096);
      end
      // zero depth through a rotation: z' = x*s + z*c must cancel the offset
      set_all(PLANE_XZ, 16'd0, 16'd16384, 16'hf000, 11'd2047, 11'd2047);
      send_vertex(16'sd4096, 16'sd0, 16'sd0);
      // zero-sized screen and full-range registers
      set_all(PLANE_YZ, 16'h8000, 16'h7fff, 16'h8000, 11'd0, 11'd1);
      send_vertex(16'sd0, 16'sh7fff, 16'sh8000);
      send_vertex(16'sh8000, 16'sd12, 16'sd5);
      // write the undecoded index with the block idle; nothing may change
      wait_drained();
      write_register(REG_UNUSED, 32'hffff_ffff);
      send_vertex(16'sd300, 16'sd300, 16'sd300);
   endtask

   // Fill the pipeline while the receiver holds off, so the block stalls its input
   task automatic test_backpressure();
      set_all(PLANE_XY, 16'd16384, 16'd0, 16'd8192, 11'd700, 11'd700);
      sender_idles = 1'b0;
      receiver_hold = 300;
      repeat (80) send_random_vertex();
      sender_idles = 1'b1;
      wait_drained();
   endtask

   // Random vertices across many register settings, with and without idling
   task automatic test_random_stream();
      for (int phase = 0; phase < 26; phase++) begin
         randomise_registers();
         sender_idles   = (phase % 4) != 1;
         receiver_idles = (phase % 4) != 2;
         repeat (50) send_random_vertex();
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      mismatch_count = 0;
      points_checked = 0;
      zero_depth_seen = 0;
      clipped_seen = 0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      receiver_hold = 0;
      plane_sel  = RESET_PLANE;
      cosine_q14 = RESET_COSINE;
      sine_q14   = RESET_SINE;
      depth_q12  = RESET_DEPTH;
      width_px   = RESET_SCREEN;
      height_px  = RESET_SCREEN;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_field_extremes();
      test_backpressure();
      test_random_stream();
      wait_drained();

      $display("checked %0d projected vertices over 34 register settings", points_checked);
      $display("%0d at zero depth, %0d clipped", zero_depth_seen, clipped_seen);
      if (mismatch_count == 0 && expected_points.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #8ms;
      $display("timeout with %0d results outstanding", expected_points.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
